FILE: rtl/twrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twrm_pkg;

  localparam int UNIT_W = 10;
  localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 10'd20;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_AW = 3;
  localparam logic REG_UNIT_TICKS = 1'b0;
  localparam logic [7:0] CMD_MARK = 8'h80;
  localparam logic [6:0] BCD_MAX = 7'd99;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BEGIN,
    PH_OUT,
    PH_IN,
    PH_END_HOLD,
    PH_END_OFF
  } phase_t;

  // classified word handed from front to back
  typedef struct packed {
    logic       is_tick;
    logic       is_read;
    logic [7:0] cmd;
    logic [7:0] data;
    logic       io_in;
  } item_t;

  typedef struct packed {
    logic       ce_pin;
    logic       sclk_pin;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic       rejected;
    logic [7:0] read_raw;
    logic [7:0] read_value;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/twrm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module twrm_fifo #(
  parameter int DEPTH = 2,
  parameter type T = logic
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  push,
  input  T     din,
  output logic full,
  input  wire  pop,
  output T     dout,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T               mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/twrm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module twrm_front #(
  parameter int DEPTH = 2
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  output logic            full,
  input  wire             mode,
  input  wire             is_read,
  input  wire  [4:0]      reg_index,
  input  wire  [6:0]      write_value,
  input  wire             io_in,
  input  wire             q_pop,
  output twrm_pkg::item_t q_item,
  output logic            q_empty
);

  import twrm_pkg::*;

  item_t       item;
  logic [6:0]  val;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [3:0]  ones;

  // clamp, then tens = v*205 >> 11 (exact below 180)
  always_comb begin
    val      = (write_value > BCD_MAX) ? BCD_MAX : write_value;
    prod     = 15'(val) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    ones     = 4'(val - tens_x10);
  end

  always_comb begin
    item.is_tick = mode;
    item.is_read = is_read;
    item.cmd     = CMD_MARK | {2'b00, reg_index, is_read};
    item.data    = is_read ? 8'h00 : {tens, ones};
    item.io_in   = io_in;
  end

  twrm_fifo #(
    .DEPTH (DEPTH),
    .T     (item_t)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (item),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

endmodule

`default_nettype wire

FILE: rtl/twrm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module twrm_back (
  input  wire                        clk,
  input  wire                        rst,
  input  wire  [twrm_pkg::UNIT_W-1:0] unit_ticks,
  input  twrm_pkg::item_t            q_item,
  input  wire                        q_empty,
  output logic                       q_pop,
  output twrm_pkg::res_t             res,
  output logic                       res_push,
  input  wire                        res_full
);

  import twrm_pkg::*;

  phase_t            phase, phase_next;
  logic [2:0]        bit_count, bit_count_next;
  logic              byte_count, byte_count_next;
  logic              clock_half, clock_half_next;
  logic [UNIT_W-1:0] unit_counter, unit_counter_next;
  logic [7:0]        tx_shift, tx_shift_next;
  logic [7:0]        data_byte, data_byte_next;
  logic [7:0]        rx_shift, rx_shift_next;
  logic              read_flag, read_flag_next;
  logic              done, rej;

  logic              fire;
  logic [UNIT_W-1:0] units;
  logic [UNIT_W:0]   cnt_inc;
  logic [3:0]        b4;

  assign fire     = ~q_empty & ~res_full;
  assign q_pop    = fire;
  assign res_push = fire;
  assign units    = (unit_ticks == '0) ? UNIT_W'(1) : unit_ticks;
  assign cnt_inc  = {1'b0, unit_counter} + 1'b1;
  assign b4       = {1'b0, bit_count} + 1'b1;

  // next state
  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    byte_count_next   = byte_count;
    clock_half_next   = clock_half;
    unit_counter_next = unit_counter;
    tx_shift_next     = tx_shift;
    data_byte_next    = data_byte;
    rx_shift_next     = rx_shift;
    read_flag_next    = read_flag;
    done              = 1'b0;
    rej               = 1'b0;
    if (!q_item.is_tick) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        read_flag_next    = q_item.is_read;
        tx_shift_next     = q_item.cmd;
        data_byte_next    = q_item.data;
        bit_count_next    = '0;
        byte_count_next   = 1'b0;
        clock_half_next   = 1'b0;
        unit_counter_next = '0;
        phase_next        = PH_BEGIN;
      end
    end else if (phase != PH_IDLE) begin
      if (cnt_inc < {1'b0, units}) begin
        unit_counter_next = cnt_inc[UNIT_W-1:0];
      end else begin
        unit_counter_next = '0;
        unique case (phase)
          PH_BEGIN: begin
            phase_next      = PH_OUT;
            bit_count_next  = '0;
            byte_count_next = 1'b0;
            clock_half_next = 1'b0;
          end
          PH_OUT: begin
            if (!clock_half) begin
              clock_half_next = 1'b1;
            end else begin
              clock_half_next = 1'b0;
              bit_count_next  = b4[2:0];
              if (b4[3]) begin
                bit_count_next = '0;
                if (!byte_count) begin
                  if (read_flag) begin
                    phase_next       = PH_IN;
                    rx_shift_next[0] = q_item.io_in;
                  end else begin
                    byte_count_next = 1'b1;
                    tx_shift_next   = data_byte;
                  end
                end else begin
                  phase_next = PH_END_HOLD;
                end
              end
            end
          end
          PH_IN: begin
            if (!clock_half) begin
              clock_half_next = 1'b1;
            end else begin
              clock_half_next        = 1'b0;
              rx_shift_next[b4[2:0]] = q_item.io_in;
              if (b4 >= 4'd7) begin
                phase_next     = PH_END_HOLD;
                bit_count_next = '0;
              end else begin
                bit_count_next = b4[2:0];
              end
            end
          end
          PH_END_HOLD: phase_next = PH_END_OFF;
          PH_END_OFF: begin
            phase_next = PH_IDLE;
            done       = 1'b1;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // result word from the updated state
  always_comb begin
    res          = '0;
    res.busy_res = (phase_next != PH_IDLE);
    res.done_res = done;
    res.rejected = rej;
    res.read_raw = rx_shift_next;
    res.read_value = 8'({rx_shift_next[7:4], 3'b000}) + 8'({rx_shift_next[7:4], 1'b0})
                   + 8'(rx_shift_next[3:0]);
    unique case (phase_next)
      PH_BEGIN: begin
        res.ce_pin   = 1'b1;
        res.io_drive = 1'b1;
      end
      PH_OUT: begin
        res.ce_pin   = 1'b1;
        res.sclk_pin = ~clock_half_next;
        res.io_drive = ~(read_flag_next & ~byte_count_next & (bit_count_next == 3'd7)
                         & clock_half_next);
        res.io_out   = res.io_drive & tx_shift_next[bit_count_next];
      end
      PH_IN: begin
        res.ce_pin   = 1'b1;
        res.sclk_pin = ~clock_half_next;
      end
      PH_END_HOLD: begin
        res.ce_pin   = 1'b1;
        res.io_drive = ~read_flag_next;
      end
      default: res.io_drive = ~read_flag_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      byte_count   <= 1'b0;
      clock_half   <= 1'b0;
      unit_counter <= '0;
      tx_shift     <= '0;
      data_byte    <= '0;
      rx_shift     <= '0;
      read_flag    <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      byte_count   <= byte_count_next;
      clock_half   <= clock_half_next;
      unit_counter <= unit_counter_next;
      tx_shift     <= tx_shift_next;
      data_byte    <= data_byte_next;
      rx_shift     <= rx_shift_next;
      read_flag    <= read_flag_next;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.done_res |-> !res.busy_res)
    else $error("done reported while still busy");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    fire && res.rejected |-> res.busy_res && (phase_next == phase))
    else $error("reject outside a transaction");

  a_in_is_read: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IN |-> read_flag)
    else $error("receive phase in a write transaction");

  a_data_is_write: assert property (@(posedge clk) disable iff (rst)
    byte_count |-> !read_flag)
    else $error("data byte phase in a read transaction");

endmodule

`default_nettype wire

FILE: rtl/three_wire_rtc_register_master.sv
`timescale 1ns / 1ps
`default_nettype none
// A word passes the input queue and back end into the result queue (empty low).
// Throughput: one word per clock, sustained, as long as results are popped.
// Back end: one word per cycle when not stalled; both queues decouple stalls.
// Reset (rst, synchronous, active high): queues empty, transaction idle,
// shift registers cleared, unit_ticks back to 20.
module three_wire_rtc_register_master #(
  parameter int IN_DEPTH  = twrm_pkg::QUEUE_DEPTH,
  parameter int OUT_DEPTH = twrm_pkg::QUEUE_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst,
  // input queue side
  input  wire                          push,
  output logic                         full,
  input  wire                          mode,
  input  wire                          is_read,
  input  wire  [4:0]                   reg_index,
  input  wire  [6:0]                   write_value,
  input  wire                          io_in,
  // result queue side
  output logic                         empty,
  input  wire                          pop,
  output logic                         ce_pin,
  output logic                         sclk_pin,
  output logic                         io_out,
  output logic                         io_drive,
  output logic                         busy_res,
  output logic                         done_res,
  output logic                         rejected,
  output logic [7:0]                   read_raw,
  output logic [7:0]                   read_value,
  // configuration
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [twrm_pkg::CFG_AW-1:0]  paddr,
  input  wire  [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  import twrm_pkg::*;

  // unit_ticks: timing unit length in tick words (0 behaves as 1)
  logic [UNIT_W-1:0] unit_ticks;
  logic              cfg_wr;
  logic              reg_hit;

  item_t q_item;
  logic  q_empty;
  logic  q_pop;
  res_t  res;
  logic  res_push;
  logic  res_full;
  res_t  res_head;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_AW-1:2] == REG_UNIT_TICKS);
  assign cfg_wr  = psel & penable & pwrite & pready & reg_hit;
  assign prdata  = reg_hit ? 32'(unit_ticks) : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks <= UNIT_TICKS_RESET;
    end else if (cfg_wr) begin
      unit_ticks <= pwdata[UNIT_W-1:0];
    end
  end

  // Front: classifies each word and precomputes the command and BCD bytes.
  twrm_front #(
    .DEPTH (IN_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .mode        (mode),
    .is_read     (is_read),
    .reg_index   (reg_index),
    .write_value (write_value),
    .io_in       (io_in),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .q_empty     (q_empty)
  );

  // Back: pin sequencer, one word per cycle when the result queue has room.
  twrm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .unit_ticks (unit_ticks),
    .q_item     (q_item),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .res        (res),
    .res_push   (res_push),
    .res_full   (res_full)
  );

  // Result queue: a finished word waits here while the back keeps working.
  twrm_fifo #(
    .DEPTH (OUT_DEPTH),
    .T     (res_t)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_head),
    .empty (empty)
  );

  assign ce_pin     = res_head.ce_pin;
  assign sclk_pin   = res_head.sclk_pin;
  assign io_out     = res_head.io_out;
  assign io_drive   = res_head.io_drive;
  assign busy_res   = res_head.busy_res;
  assign done_res   = res_head.done_res;
  assign rejected   = res_head.rejected;
  assign read_raw   = res_head.read_raw;
  assign read_value = res_head.read_value;

endmodule

`default_nettype wire
